[sv/ndarma_pkg.sv]
// Package for the noise-driven ARMA filter: widths, codes, sequencer states
// and the control bundle of the shared multiply-accumulate unit.
// No dependencies; every other file of the block imports it.
package ndarma_pkg;

    localparam int DATA_W     = 32;              // Q8.24 sample and coefficient width
    localparam int OPA_W      = DATA_W + 1;      // first operand, room for a negated coefficient
    localparam int PROD_W     = OPA_W + DATA_W;  // full product width
    localparam int ACC_W      = 48;              // accumulator, covers 65 rounded products
    localparam int FRAC_W     = 24;              // fraction bits of Q8.24
    localparam int MODE_W     = 3;
    localparam int INDEX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int AR_ORD_W   = 6;
    localparam int MA_ORD_W   = 5;

    localparam int DEF_AR_TAPS      = 32;
    localparam int DEF_MA_TAPS      = 16;
    localparam int DEF_SAMPLE_WIDTH = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 3'd0,
        MODE_AR     = 3'd1,
        MODE_MA     = 3'd2,
        MODE_GAIN   = 3'd3,
        MODE_STD    = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AR_ORDER = 2'd0,
        CFG_MA_ORDER = 2'd1,
        CFG_ARMA_EN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXC,
        ST_EXC_W,
        ST_ELATCH,
        ST_MA,
        ST_MA_W,
        ST_GAIN,
        ST_AR,
        ST_AR_W,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic issue;  // a product enters the multiplier this cycle
        logic load;   // the accumulator takes the load value this cycle
    } mac_cmd_t;

endpackage

[sv/ndarma_in_if.sv]
// Input channel of the noise-driven ARMA filter: valid/ready plus one item.
// Depends on ndarma_pkg for the field widths.
interface ndarma_in_if import ndarma_pkg::*;;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic                       bank;
    logic [INDEX_W-1:0]         index;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   noise;

    modport source (output valid, output mode, output bank, output index,
                    output value, output noise, input ready);
    modport sink   (input valid, input mode, input bank, input index,
                    input value, input noise, output ready);

endinterface

[sv/ndarma_out_if.sv]
// Output channel of the noise-driven ARMA filter: valid/ready plus one result.
// Depends on ndarma_pkg for the field widths.
interface ndarma_out_if import ndarma_pkg::*;;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   vibration;
    logic                       saturated;

    modport source (output valid, output vibration, output saturated, input ready);
    modport sink   (input valid, input vibration, input saturated, output ready);

endinterface

[sv/ndarma_mac.sv]
// Shared multiply-accumulate unit of the ARMA filter: a registered product
// followed by a Q8.24 rounding accumulator. Depends on ndarma_pkg.
module ndarma_mac import ndarma_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_cmd_t                 cmd,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [DATA_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]  load_val,
    output logic signed [ACC_W-1:0]  acc
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    logic signed [ACC_W-1:0]  term;

    // Round to nearest with ties toward plus infinity; the arithmetic shift
    // is a floor, which matches the fixed-point rounding rule.
    always_comb
    begin
        biased  = prod_reg + ROUND_HALF;
        shifted = biased >>> FRAC_W;
        term    = shifted[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cmd.load)
        begin
            acc_reg <= load_val;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

[sv/noise_driven_arma_filter_top.sv]
// Top level of the noise-driven ARMA vibration filter: coefficient memories,
// histories, sequencer and output register. Depends on ndarma_pkg,
// ndarma_in_if, ndarma_out_if and ndarma_mac.
//
// Usage. Items arrive on the item channel and are taken on a beat where valid
// and ready are both high. Modes 1 to 4 load an AR coefficient, an MA
// coefficient, the gain or the noise standard deviation of the selected bank;
// each yields no result and leaves the block idle. Mode 0 runs one sample
// step and yields one beat on the result channel; unused modes are dropped.
// The user must write the three registers (AR order, MA order, ARMA enable)
// through cfg_we/cfg_idx/cfg_data only while the block is idle (not enforced).
//
// Sequence. One multiplier-accumulator is shared by every product, so a sample
// step runs its phases in turn: the excitation, the MA pass and the gain
// product when ARMA mode is on, then the AR pass. The AR and MA passes walk
// every tap slot, one slot per cycle, so the length of a step does not depend
// on the orders. Ready stays low from the accepting beat until the result beat
// becomes valid.
//
// Reset clears the registers, the histories and the control state; the
// coefficient stores stay unknown until written. A stalled receiver holds the
// result register; a following sample may run meanwhile and waits in its
// final cycle until the register is free.
module noise_driven_arma_filter_top import ndarma_pkg::*;
#(
    parameter int AR_TAPS      = DEF_AR_TAPS,
    parameter int MA_TAPS      = DEF_MA_TAPS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ndarma_in_if.sink             item,
    ndarma_out_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIG_W   = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
    localparam int TAP_MAX = (AR_TAPS > MA_TAPS) ? AR_TAPS : MA_TAPS;
    localparam int CNT_W   = $clog2(TAP_MAX + 1);
    localparam int CMP_W   = (CNT_W > AR_ORD_W) ? CNT_W : AR_ORD_W;
    localparam int IDX_CMP_W = 7;
    localparam int AR_AW   = $clog2(2 * AR_TAPS);
    localparam int MA_AW   = $clog2(2 * MA_TAPS);

    localparam logic signed [ACC_W-1:0] SIG_MAX = (ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SIG_MIN = -SIG_MAX - ACC_W'(1);

    // Configuration registers.
    logic [AR_ORD_W-1:0] ar_order_reg;
    logic [MA_ORD_W-1:0] ma_order_reg;
    logic                arma_en_reg;

    // Coefficient stores; their contents are unknown until written.
    logic signed [DATA_W-1:0] ar_mem [2*AR_TAPS];
    logic signed [DATA_W-1:0] ma_mem [2*MA_TAPS];
    logic signed [DATA_W-1:0] gain_reg [2];
    logic signed [DATA_W-1:0] sd_reg [2];
    logic signed [DATA_W-1:0] ar_q_reg;
    logic signed [DATA_W-1:0] ma_q_reg;

    // Histories: entry 0 is the newest sample. During a pass they rotate so
    // that the tap under work always sits in entry 0.
    logic signed [DATA_W-1:0] ohist_reg [AR_TAPS];
    logic signed [DATA_W-1:0] ehist_reg [MA_TAPS];

    // Sequencer and step state.
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     bank_reg;
    logic signed [DATA_W-1:0] noise_reg;
    logic signed [DATA_W-1:0] e_reg;
    logic                     flag_reg;
    logic                     rd_v_reg;
    logic                     rd_ma_reg;
    logic signed [DATA_W-1:0] hb_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] vib_reg;
    logic                     sat_reg;

    // Shared unit connections.
    mac_cmd_t                 mac_cmd;
    logic signed [OPA_W-1:0]  mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  mac_load;
    logic signed [ACC_W-1:0]  mac_acc;

    logic                     in_fire;
    logic                     out_free;
    logic                     done_fire;
    logic                     clip;
    logic signed [ACC_W-1:0]  sat_val;
    logic signed [DATA_W-1:0] sat32;
    logic [AR_AW-1:0]         ar_raddr, ar_waddr;
    logic [MA_AW-1:0]         ma_raddr, ma_waddr;
    logic                     ar_widx_ok, ma_widx_ok;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_fire    = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign done_fire  = (state_reg == ST_DONE) && out_free;

    // Clip the accumulator to the signal range; used for the excitation, the
    // ARMA inner sum and the final output alike.
    always_comb
    begin
        clip    = 1'b0;
        sat_val = mac_acc;
        if (mac_acc > SIG_MAX)
        begin
            clip    = 1'b1;
            sat_val = SIG_MAX;
        end
        else if (mac_acc < SIG_MIN)
        begin
            clip    = 1'b1;
            sat_val = SIG_MIN;
        end
        sat32 = sat_val[DATA_W-1:0];
    end

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_order_reg <= '0;
            ma_order_reg <= '0;
            arma_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_AR_ORDER: ar_order_reg <= cfg_data[AR_ORD_W-1:0];
                CFG_MA_ORDER: ma_order_reg <= cfg_data[MA_ORD_W-1:0];
                CFG_ARMA_EN:  arma_en_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Coefficient addressing: bank 1 occupies the upper half of each store.
    always_comb
    begin
        ar_raddr   = bank_reg ? AR_AW'(AR_TAPS) + AR_AW'(cnt_reg) : AR_AW'(cnt_reg);
        ma_raddr   = bank_reg ? MA_AW'(MA_TAPS) + MA_AW'(cnt_reg) : MA_AW'(cnt_reg);
        ar_waddr   = item.bank ? AR_AW'(AR_TAPS) + AR_AW'(item.index)
                               : AR_AW'(item.index);
        ma_waddr   = item.bank ? MA_AW'(MA_TAPS) + MA_AW'(item.index)
                               : MA_AW'(item.index);
        ar_widx_ok = IDX_CMP_W'(item.index) < IDX_CMP_W'(AR_TAPS);
        ma_widx_ok = IDX_CMP_W'(item.index) < IDX_CMP_W'(MA_TAPS);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (item.mode == MODE_AR) && ar_widx_ok)
        begin
            ar_mem[ar_waddr] <= item.value;
        end
        if (in_fire && (item.mode == MODE_MA) && ma_widx_ok)
        begin
            ma_mem[ma_waddr] <= item.value;
        end
        if (in_fire && (item.mode == MODE_GAIN))
        begin
            gain_reg[item.bank] <= item.value;
        end
        if (in_fire && (item.mode == MODE_STD))
        begin
            sd_reg[item.bank] <= item.value;
        end
        ar_q_reg <= ar_mem[ar_raddr];
        ma_q_reg <= ma_mem[ma_raddr];
    end

    // Sequencer: next state and the commands to the shared unit.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mac_cmd    = '0;
        mac_cmd.issue = rd_v_reg;
        mac_a      = rd_ma_reg ? OPA_W'(ma_q_reg) : -OPA_W'(ar_q_reg);
        mac_b      = hb_reg;
        mac_load   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (item.mode == MODE_SAMPLE))
                begin
                    state_next = ST_EXC;
                end
            end
            ST_EXC:
            begin
                // Excitation: std deviation times noise, into a cleared sum.
                mac_cmd.issue = 1'b1;
                mac_cmd.load  = 1'b1;
                mac_a         = OPA_W'(sd_reg[bank_reg]);
                mac_b         = noise_reg;
                state_next    = ST_EXC_W;
            end
            ST_EXC_W:
            begin
                state_next = ST_ELATCH;
            end
            ST_ELATCH:
            begin
                // The clipped excitation seeds either the MA sum or the output.
                mac_cmd.load = 1'b1;
                mac_load     = sat_val;
                cnt_next     = '0;
                state_next   = arma_en_reg ? ST_MA : ST_AR;
            end
            ST_MA:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MA_TAPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MA_W;
                end
            end
            ST_MA_W:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                // Gain times the clipped inner sum starts the output sum.
                mac_cmd.issue = 1'b1;
                mac_cmd.load  = 1'b1;
                mac_a         = OPA_W'(gain_reg[bank_reg]);
                mac_b         = sat32;
                cnt_next      = '0;
                state_next    = ST_AR;
            end
            ST_AR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(AR_TAPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_AR_W;
                end
            end
            ST_AR_W:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_v_reg  <= 1'b0;
            if (state_reg == ST_MA)
            begin
                rd_v_reg <= CMP_W'(cnt_reg) < CMP_W'(ma_order_reg);
            end
            else if (state_reg == ST_AR)
            begin
                rd_v_reg <= CMP_W'(cnt_reg) < CMP_W'(ar_order_reg);
            end
        end
    end

    // Step payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bank_reg  <= item.bank;
            noise_reg <= item.noise;
        end
        if (state_reg == ST_EXC)
        begin
            flag_reg <= 1'b0;
        end
        if (state_reg == ST_ELATCH)
        begin
            e_reg    <= sat32;
            flag_reg <= flag_reg | clip;
        end
        if (state_reg == ST_GAIN)
        begin
            flag_reg <= flag_reg | clip;
        end
        if (state_reg == ST_MA)
        begin
            rd_ma_reg <= 1'b1;
            hb_reg    <= ehist_reg[0];
        end
        else if (state_reg == ST_AR)
        begin
            rd_ma_reg <= 1'b0;
            hb_reg    <= ohist_reg[0];
        end
    end

    // Histories: rotate one place per pass cycle, then shift in the new
    // samples at the end of the step, dropping entries beyond the order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AR_TAPS; i++)
            begin
                ohist_reg[i] <= '0;
            end
            for (int i = 0; i < MA_TAPS; i++)
            begin
                ehist_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_AR)
        begin
            for (int i = 0; i < AR_TAPS; i++)
            begin
                ohist_reg[i] <= ohist_reg[(i + 1) % AR_TAPS];
            end
        end
        else if (state_reg == ST_MA)
        begin
            for (int i = 0; i < MA_TAPS; i++)
            begin
                ehist_reg[i] <= ehist_reg[(i + 1) % MA_TAPS];
            end
        end
        else if (done_fire)
        begin
            ohist_reg[0] <= sat32;
            for (int i = 1; i < AR_TAPS; i++)
            begin
                ohist_reg[i] <= (CMP_W'(i - 1) < CMP_W'(ar_order_reg)) ? ohist_reg[i-1] : '0;
            end
            ehist_reg[0] <= e_reg;
            for (int i = 1; i < MA_TAPS; i++)
            begin
                ehist_reg[i] <= (CMP_W'(i - 1) < CMP_W'(ma_order_reg)) ? ehist_reg[i-1] : '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            vib_reg <= sat32;
            sat_reg <= flag_reg | clip;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.vibration = vib_reg;
    assign result.saturated = sat_reg;

    ndarma_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .op_a     (mac_a),
        .op_b     (mac_b),
        .load_val (mac_load),
        .acc      (mac_acc)
    );

endmodule

[bench/tb_noise_driven_arma_filter_top.sv]
// Self-checking testbench for noise_driven_arma_filter_top: drives items and register
// writes, predicts every vibration sample and compares each result beat field by field.
// Depends on ndarma_pkg, ndarma_in_if, ndarma_out_if and the RTL of the filter.
module tb_noise_driven_arma_filter_top import ndarma_pkg::*;;

    // The bench runs the block at its default sizes.
    localparam int AR_TAPS = DEF_AR_TAPS;
    localparam int MA_TAPS = DEF_MA_TAPS;

    // Signal range of the outputs: SAMPLE_WIDTH bits, which is 32 at the defaults.
    localparam longint SIG_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam longint SIG_MIN = -SIG_MAX - 64'sd1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0100_0000;

    // Longer than the slowest sample step, so this covers any item still in flight.
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_GUARD   = 20000;

    typedef struct {
        logic signed [DATA_W-1:0] vibration;
        logic                     saturated;
    } vib_sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ndarma_in_if  item_ch ();
    ndarma_out_if result_ch ();

    noise_driven_arma_filter_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the filter: both coefficient banks, the two histories and the
    // three registers. It is advanced at every accepted beat on the item channel.
    longint      ar_coef [2][AR_TAPS];
    longint      ma_coef [2][MA_TAPS];
    longint      gain_q  [2];
    longint      std_q   [2];
    longint      y_hist  [AR_TAPS];
    longint      e_hist  [MA_TAPS];
    int unsigned ar_order_reg;
    int unsigned ma_order_reg;
    bit          arma_on;

    // Samples that the block still owes us, oldest first.
    vib_sample_t expected_samples [$];

    int unsigned errors = 0;        // mismatches seen by the result checker
    int unsigned lost_samples = 0;  // samples that never came back
    bit          calm;  // when set, neither side inserts idle cycles

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: ready is redrawn at every falling edge and is low with a chance of about 30 percent,
    // unless a calm stretch is running.
    always @(negedge clk)
    begin
        result_ch.ready = calm || ($urandom_range(99) >= 30);
    end

    // Product of two Q8.24 values rounded back to Q8.24 by adding half an LSB and
    // flooring; the arithmetic shift of a signed longint is a floor.
    function automatic longint q_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint clip(input longint v, inout bit hit);
        if (v > SIG_MAX)
        begin
            hit = 1'b1;
            return SIG_MAX;
        end
        if (v < SIG_MIN)
        begin
            hit = 1'b1;
            return SIG_MIN;
        end
        return v;
    endfunction

    // One sample step of the filter on the given bank. The histories keep the
    // clipped values, and entries at or beyond the order are cleared before the shift.
    function automatic vib_sample_t filter_sample(input logic bank,
                                                  input logic signed [DATA_W-1:0] noise);
        vib_sample_t res;
        int unsigned ar_n;
        int unsigned ma_n;
        longint      e;
        longint      m;
        longint      acc;
        bit          hit;
        ar_n = (ar_order_reg < AR_TAPS) ? ar_order_reg : AR_TAPS;
        ma_n = (ma_order_reg < MA_TAPS) ? ma_order_reg : MA_TAPS;
        hit  = 1'b0;
        e    = clip(q_product(std_q[bank], longint'(noise)), hit);
        acc  = 0;
        for (int i = 0; i < ar_n; i++)
            acc += q_product(-ar_coef[bank][i], y_hist[i]);
        if (arma_on)
        begin
            m = e;
            for (int i = 0; i < ma_n; i++)
                m += q_product(ma_coef[bank][i], e_hist[i]);
            m = clip(m, hit);
            acc += q_product(gain_q[bank], m);
        end
        else
        begin
            acc += e;
        end
        acc = clip(acc, hit);
        for (int i = ar_n; i < AR_TAPS; i++)
            y_hist[i] = 0;
        for (int i = ma_n; i < MA_TAPS; i++)
            e_hist[i] = 0;
        for (int i = AR_TAPS - 1; i > 0; i--)
            y_hist[i] = y_hist[i-1];
        for (int i = MA_TAPS - 1; i > 0; i--)
            e_hist[i] = e_hist[i-1];
        y_hist[0]     = acc;
        e_hist[0]     = e;
        res.vibration = acc[DATA_W-1:0];
        res.saturated = hit;
        return res;
    endfunction

    // Applies one accepted item to the shadow copy. Writes whose index is beyond the
    // tap count and the unused modes change nothing and produce no sample.
    function automatic void absorb_item(input logic [MODE_W-1:0] mode, input logic bank,
                                        input logic [INDEX_W-1:0] index,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic signed [DATA_W-1:0] noise);
        case (mode)
            MODE_SAMPLE: expected_samples.insert(expected_samples.size(),
                                                 filter_sample(bank, noise));
            MODE_AR:     if (index < AR_TAPS) ar_coef[bank][index] = longint'(value);
            MODE_MA:     if (index < MA_TAPS) ma_coef[bank][index] = longint'(value);
            MODE_GAIN:   gain_q[bank] = longint'(value);
            MODE_STD:    std_q[bank]  = longint'(value);
            default:     ;
        endcase
    endfunction

    // Sends one item: random idle cycles first, then valid is held with stable fields
    // until the block takes the beat.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic bank,
                             input logic [INDEX_W-1:0] index,
                             input logic signed [DATA_W-1:0] value,
                             input logic signed [DATA_W-1:0] noise);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 30)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.mode  = mode;
        item_ch.bank  = bank;
        item_ch.index = index;
        item_ch.value = value;
        item_ch.noise = noise;
        do
            @(posedge clk);
        while (!item_ch.ready);
        absorb_item(mode, bank, index, value, noise);
    endtask

    // Lowers valid and waits until every owed sample has come back, then lets the
    // block run out any write that may still be in progress.
    task automatic wait_for_quiet();
        int unsigned guard;
        @(negedge clk);
        item_ch.valid = 1'b0;
        guard = 0;
        while (expected_samples.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_samples.size() != 0)
        begin
            $error("%0d expected samples never arrived", expected_samples.size());
            lost_samples += expected_samples.size();
            expected_samples.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input int unsigned data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data[CFG_DATA_W-1:0];
        case (idx)
            CFG_AR_ORDER: ar_order_reg = data[AR_ORD_W-1:0];
            CFG_MA_ORDER: ma_order_reg = data[MA_ORD_W-1:0];
            CFG_ARMA_EN:  arma_on      = data[0];
            default:      ;
        endcase
    endtask

    // Only called while the block is idle, after wait_for_quiet.
    task automatic configure(input int unsigned ar, input int unsigned ma,
                             input int unsigned en);
        write_register(CFG_AR_ORDER, ar);
        write_register(CFG_MA_ORDER, ma);
        write_register(CFG_ARMA_EN, en);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Uniform Q8.24 value with magnitude at most 2^span LSBs.
    function automatic logic signed [DATA_W-1:0] small_q(input int unsigned span);
        logic signed [DATA_W-1:0] raw;
        raw = $urandom;
        return raw >>> (DATA_W - 1 - span);
    endfunction

    // Mostly modest values, with the full range and the corner codes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return $urandom;
        if (r < 14)
        begin
            case ($urandom_range(3))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return small_q(span);
    endfunction

    // Every coefficient, gain and standard deviation of both banks is written before
    // the first sample, since the block walks all tap slots and unwritten entries
    // must never be read.
    task automatic test_bank_load();
        for (int b = 0; b < 2; b++)
        begin
            for (int i = 0; i < AR_TAPS; i++)
                send_item(MODE_AR, b[0], i[INDEX_W-1:0], small_q(19), $urandom);
            for (int i = 0; i < MA_TAPS; i++)
                send_item(MODE_MA, b[0], i[INDEX_W-1:0], small_q(22), $urandom);
            send_item(MODE_GAIN, b[0], INDEX_W'($urandom), Q_ONE + small_q(22), $urandom);
            send_item(MODE_STD, b[0], INDEX_W'($urandom), small_q(24), $urandom);
        end
    endtask

    // Corner items: clipped excitation at both rails, rounding of the smallest noise,
    // the unused modes, MA writes beyond the taps, orders above the tap counts and
    // gains that clip the ARMA inner sum and the final output.
    task automatic test_corner_items();
        wait_for_quiet();
        configure(0, 0, 0);
        send_item(MODE_STD, 1'b0, '0, Q_MAX, $urandom);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, Q_MAX);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, Q_MIN);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, '0);
        send_item(MODE_STD, 1'b0, '1, Q_ONE, $urandom);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, 32'sd1);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, -32'sd1);
        for (int m = int'(MODE_STD) + 1; m < 2 ** MODE_W; m++)
            send_item(m[MODE_W-1:0], 1'($urandom), INDEX_W'($urandom), $urandom, $urandom);
        // These two land beyond the MA taps and must leave the banks alone.
        send_item(MODE_MA, 1'b0, INDEX_W'(MA_TAPS), Q_MAX, $urandom);
        send_item(MODE_MA, 1'b1, '1, Q_MIN, $urandom);
        send_item(MODE_AR, 1'b1, '1, Q_ONE >>> 2, $urandom);
        send_item(MODE_AR, 1'b0, '0, Q_MIN, $urandom);
        wait_for_quiet();
        configure(2 ** AR_ORD_W - 1, 2 ** MA_ORD_W - 1, 1);
        send_item(MODE_GAIN, 1'b0, INDEX_W'($urandom), Q_MAX, $urandom);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, Q_MAX);
        send_item(MODE_GAIN, 1'b0, INDEX_W'($urandom), Q_MIN, $urandom);
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, 32'sh4000_0000);
        send_item(MODE_AR, 1'b0, '0, small_q(19), $urandom);
        send_item(MODE_GAIN, 1'b0, INDEX_W'($urandom), Q_ONE, $urandom);
        send_item(MODE_SAMPLE, 1'b1, INDEX_W'($urandom), $urandom, small_q(25));
        send_item(MODE_SAMPLE, 1'b0, INDEX_W'($urandom), $urandom, small_q(25));
    endtask

    // Random traffic: about half sample steps, the rest coefficient writes with
    // random content. Unused modes are sprinkled in but not counted.
    task automatic run_random_items(input int unsigned count);
        int unsigned done;
        int unsigned pick;
        logic        b;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            b    = 1'($urandom_range(1));
            done++;
            if (pick < 55)
                send_item(MODE_SAMPLE, b, INDEX_W'($urandom), $urandom, pick_value(25));
            else if (pick < 70)
                send_item(MODE_AR, b, INDEX_W'($urandom), pick_value(19), $urandom);
            else if (pick < 80)
                send_item(MODE_MA, b, INDEX_W'($urandom), pick_value(22), $urandom);
            else if (pick < 87)
                send_item(MODE_GAIN, b, INDEX_W'($urandom), pick_value(24), $urandom);
            else if (pick < 94)
                send_item(MODE_STD, b, INDEX_W'($urandom), pick_value(24), $urandom);
            else
            begin
                send_item(MODE_W'($urandom_range(2 ** MODE_W - 1, int'(MODE_STD) + 1)), b,
                          INDEX_W'($urandom), $urandom, $urandom);
                done--;
            end
        end
    endtask

    // Fixed settings: full orders with ARMA, zero orders without it, pure AR at the
    // maximum orders, the shortest nonzero filter and orders just above the tap counts.
    task automatic test_order_sweep();
        wait_for_quiet();
        configure(AR_TAPS, MA_TAPS, 1);
        run_random_items(100);
        wait_for_quiet();
        configure(0, 0, 0);
        run_random_items(200);
        wait_for_quiet();
        configure(2 ** AR_ORD_W - 1, 2 ** MA_ORD_W - 1, 0);
        run_random_items(200);
        wait_for_quiet();
        configure(1, 1, 1);
        run_random_items(200);
        wait_for_quiet();
        configure(AR_TAPS + 1, MA_TAPS + 1, 1);
        run_random_items(200);
    endtask

    task automatic test_random_orders();
        for (int p = 0; p < 4; p++)
        begin
            wait_for_quiet();
            configure($urandom_range(2 ** AR_ORD_W - 1), $urandom_range(2 ** MA_ORD_W - 1),
                      $urandom_range(1));
            run_random_items(130);
        end
    endtask

    // A long run in which neither side idles, so each item is offered as soon as the block can take it.
    task automatic test_steady_stream();
        wait_for_quiet();
        configure($urandom_range(AR_TAPS), $urandom_range(MA_TAPS), 1);
        calm = 1'b1;
        run_random_items(150);
        calm = 1'b0;
    endtask

    // The sender stops until every owed sample has come, then carries on with the
    // same setting and the same histories.
    task automatic test_sender_pause();
        run_random_items(70);
        wait_for_quiet();
        run_random_items(70);
    endtask

    // Compares every result beat with the oldest owed sample.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("result beat with no sample expected: vibration %h saturated %b",
                       result_ch.vibration, result_ch.saturated);
                errors++;
            end
            else
            begin
                vib_sample_t want;
                want = expected_samples.pop_front();
                if (result_ch.vibration !== want.vibration)
                begin
                    $error("vibration: expected %h, actual %h",
                           want.vibration, result_ch.vibration);
                    errors++;
                end
                if (result_ch.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b",
                           want.saturated, result_ch.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = '0;
        item_ch.bank    = 1'b0;
        item_ch.index   = '0;
        item_ch.value   = '0;
        item_ch.noise   = '0;
        calm            = 1'b0;
        // The shadow copy starts from the reset state: zero registers and histories.
        ar_order_reg = 0;
        ma_order_reg = 0;
        arma_on      = 1'b0;
        for (int b = 0; b < 2; b++)
        begin
            gain_q[b] = 0;
            std_q[b]  = 0;
            for (int i = 0; i < AR_TAPS; i++)
                ar_coef[b][i] = 0;
            for (int i = 0; i < MA_TAPS; i++)
                ma_coef[b][i] = 0;
        end
        for (int i = 0; i < AR_TAPS; i++)
            y_hist[i] = 0;
        for (int i = 0; i < MA_TAPS; i++)
            e_hist[i] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bank_load();
        test_corner_items();
        test_order_sweep();
        test_random_orders();
        test_steady_stream();
        test_sender_pause();
        wait_for_quiet();

        if (errors == 0 && lost_samples == 0)
            $display("noise_driven_arma_filter_top regression: pass");
        else
            $display("noise_driven_arma_filter_top regression: fail");
        $finish;
    end

    // Safety net: the timeout is several times the slowest correct run.
    initial
    begin
        #40000000;
        $display("noise_driven_arma_filter_top regression: fail");
        $finish;
    end

endmodule
